// ===== src/lsde_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsde_pkg
// Types, codes and constants shared by the LED strip diffusion engine.
// ----------------------------------------------------------------------------
package lsde_pkg;

	localparam int PIXEL_COUNT_DEF = 300;

	localparam int NUM_CH     = 3;
	localparam int CH_W       = 8;
	localparam int FUNC_W     = 3;
	localparam int INDEX_W    = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam int DIFF_W = 8;
	localparam int ADV_W  = 9;
	localparam int GAIN_W = 10;  // diffusion + advection, signed
	localparam int LAP_W  = 10;  // next - 2*cur, signed
	localparam int PD_W   = 19;  // diffusion * (next - 2*cur)
	localparam int PA_W   = 18;  // advection * next
	localparam int GP_W   = 19;  // (diffusion + advection) * prev
	localparam int ACC_W  = 21;  // full update sum before the divide by 256

	typedef logic [NUM_CH-1:0][CH_W-1:0] rgb_t;

	localparam logic [FUNC_W-1:0] FUNC_WRITE_PIXEL = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE_BG    = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_FILL_PIXEL  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_FILL_BG     = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_STEP        = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_READ        = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ADVECTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 2'd2;

	localparam logic [DIFF_W-1:0]        DIFFUSION_RST = 8'd207;
	localparam logic signed [ADV_W-1:0]  ADVECTION_RST = 9'sd0;
	localparam logic [CH_W-1:0]          LIMIT_RST     = 8'd100;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_STEP_A,
		ST_STEP_B,
		ST_SWEEP,
		ST_READ,
		ST_RESULT
	} state_t;

	typedef struct packed {
		rgb_t rgb;
		logic index_error;
	} result_t;

endpackage

// ===== src/led_strip_diffusion_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_diffusion_engine_top
// Per-LED colour and background stores with write, fill, read and a
// finite-difference diffusion/advection step swept through memory.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------
//  in      | in_valid / in_stall   | func, pixel_index, red/green/blue_in
//  out     | out_valid / out_stall | red/green/blue_out, index_error
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one item at a time; write and unused codes go straight to the result,
//  read passes through ST_READ, fill writes every pixel, and step runs
//  ST_STEP_A, ST_STEP_B and the sweep (one pixel per cycle through the colour
//  memory read port, the previous-pixel register closes the only loop)
//  after reset a clearing pass zeroes both memories, in_stall is high
//  meanwhile; cfg writes are taken at any time
//  a result waiting on out_stall holds the block only once the next result
//  is ready
// ----------------------------------------------------------------------------
module led_strip_diffusion_engine_top #(
	parameter int PIXEL_COUNT = lsde_pkg::PIXEL_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lsde_pkg::FUNC_W-1:0]     func,
	input  logic [lsde_pkg::INDEX_W-1:0]    pixel_index,
	input  logic [lsde_pkg::CH_W-1:0]       red_in,
	input  logic [lsde_pkg::CH_W-1:0]       green_in,
	input  logic [lsde_pkg::CH_W-1:0]       blue_in,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lsde_pkg::CH_W-1:0]       red_out,
	output logic [lsde_pkg::CH_W-1:0]       green_out,
	output logic [lsde_pkg::CH_W-1:0]       blue_out,
	output logic                            index_error,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lsde_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lsde_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(PIXEL_COUNT);
	localparam int CW = $clog2(PIXEL_COUNT + 1);
	localparam int EW = (AW > lsde_pkg::INDEX_W) ? AW : lsde_pkg::INDEX_W;
	localparam logic [AW-1:0] LAST_ADDR  = AW'(PIXEL_COUNT - 1);
	localparam logic [AW-1:0] INNER_LAST = AW'(PIXEL_COUNT - 2);
	localparam logic [AW-1:0] FIRST_IN   = AW'(1);
	localparam logic [CW-1:0] SWEEP_RD0  = CW'(2);
	localparam logic [CW-1:0] RD_END     = CW'(PIXEL_COUNT);

	localparam int NC  = lsde_pkg::NUM_CH;
	localparam int CHW = lsde_pkg::CH_W;

	// state and control
	lsde_pkg::state_t state_q, state_d;
	logic [AW-1:0]    cnt_q;
	logic [CW-1:0]    rp_q;
	logic             rv_q;
	logic [AW-1:0]    ra_q;
	logic             v_s1, v_s2;
	logic             out_valid_q;

	// configuration
	logic [lsde_pkg::DIFF_W-1:0]        diff_q;
	logic signed [lsde_pkg::ADV_W-1:0]  adv_q;
	logic [CHW-1:0]                     limit_q;
	logic signed [lsde_pkg::GAIN_W-1:0] gain_q;

	// payload
	lsde_pkg::rgb_t    fill_q;
	logic              fill_bg_q;
	lsde_pkg::result_t res_q, out_q;
	lsde_pkg::rgb_t    rdc_q, rdb_q;
	lsde_pkg::rgb_t    cur_q, bgc_q, prev_q;
	logic signed [NC-1:0][lsde_pkg::PD_W-1:0]  pd_s1;
	logic signed [NC-1:0][lsde_pkg::PA_W-1:0]  pa_s1;
	lsde_pkg::rgb_t    c_s1, bg_s1, bg_s2;
	logic [AW-1:0]     addr_s1, addr_s2;
	logic signed [NC-1:0][lsde_pkg::ACC_W-1:0] k_s2;

	// memories
	lsde_pkg::rgb_t colour_mem [PIXEL_COUNT];
	lsde_pkg::rgb_t bg_mem     [PIXEL_COUNT];

	// combinational
	logic           accept;
	logic           pix_ok;
	logic [EW-1:0]  pix_ext;
	logic [AW-1:0]  pix_addr;
	lsde_pkg::rgb_t in_rgb;
	logic           issue;
	logic           out_load;
	logic           cw_en, bw_en;
	logic [AW-1:0]  cw_addr, bw_addr, rd_addr;
	lsde_pkg::rgb_t cw_data, bw_data;
	lsde_pkg::rgb_t read_rgb;
	lsde_pkg::rgb_t new_px;
	logic signed [NC-1:0][lsde_pkg::PD_W-1:0]  pd_d;
	logic signed [NC-1:0][lsde_pkg::PA_W-1:0]  pa_d;
	logic signed [NC-1:0][lsde_pkg::ACC_W-1:0] k_d;

	assign in_stall  = (state_q != lsde_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign pix_ext   = EW'(pixel_index);
	assign pix_addr  = pix_ext[AW-1:0];
	assign pix_ok    = (32'(pixel_index) < 32'(PIXEL_COUNT));
	assign in_rgb    = {blue_in, green_in, red_in};
	assign issue     = (state_q == lsde_pkg::ST_SWEEP) && (rp_q < RD_END);
	assign out_load  = (state_q == lsde_pkg::ST_RESULT) && (!out_valid_q || !out_stall);

	assign out_valid   = out_valid_q;
	assign red_out     = out_q.rgb[0];
	assign green_out   = out_q.rgb[1];
	assign blue_out    = out_q.rgb[2];
	assign index_error = out_q.index_error;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsde_pkg::ST_CLEAR: begin
				if (cnt_q == LAST_ADDR) state_d = lsde_pkg::ST_IDLE;
			end
			lsde_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (func)
						lsde_pkg::FUNC_FILL_PIXEL: state_d = lsde_pkg::ST_FILL;
						lsde_pkg::FUNC_FILL_BG:    state_d = lsde_pkg::ST_FILL;
						lsde_pkg::FUNC_STEP:       state_d = lsde_pkg::ST_STEP_A;
						lsde_pkg::FUNC_READ: begin
							state_d = pix_ok ? lsde_pkg::ST_READ : lsde_pkg::ST_RESULT;
						end
						default:                   state_d = lsde_pkg::ST_RESULT;
					endcase
				end
			end
			lsde_pkg::ST_FILL: begin
				if (cnt_q == LAST_ADDR) state_d = lsde_pkg::ST_RESULT;
			end
			lsde_pkg::ST_STEP_A: state_d = lsde_pkg::ST_STEP_B;
			lsde_pkg::ST_STEP_B: state_d = lsde_pkg::ST_SWEEP;
			lsde_pkg::ST_SWEEP: begin
				if (v_s2 && (addr_s2 == INNER_LAST)) state_d = lsde_pkg::ST_RESULT;
			end
			lsde_pkg::ST_READ:   state_d = lsde_pkg::ST_RESULT;
			lsde_pkg::ST_RESULT: begin
				if (out_load) state_d = lsde_pkg::ST_IDLE;
			end
			default: state_d = lsde_pkg::ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		cw_en   = 1'b0;
		cw_addr = '0;
		cw_data = '0;
		bw_en   = 1'b0;
		bw_addr = '0;
		bw_data = '0;
		rd_addr = '0;
		unique case (state_q)
			lsde_pkg::ST_CLEAR: begin
				cw_en   = 1'b1;
				cw_addr = cnt_q;
				bw_en   = 1'b1;
				bw_addr = cnt_q;
			end
			lsde_pkg::ST_IDLE: begin
				cw_addr = pix_addr;
				cw_data = in_rgb;
				bw_addr = pix_addr;
				bw_data = in_rgb;
				cw_en   = accept && pix_ok && (func == lsde_pkg::FUNC_WRITE_PIXEL);
				bw_en   = accept && pix_ok && (func == lsde_pkg::FUNC_WRITE_BG);
				// a step starts by fetching the first background
				if (func == lsde_pkg::FUNC_STEP || !pix_ok) rd_addr = '0;
				else rd_addr = pix_addr;
			end
			lsde_pkg::ST_FILL: begin
				cw_en   = !fill_bg_q;
				bw_en   = fill_bg_q;
				cw_addr = cnt_q;
				bw_addr = cnt_q;
				cw_data = fill_q;
				bw_data = fill_q;
			end
			lsde_pkg::ST_STEP_A: begin
				cw_en   = 1'b1;
				cw_addr = '0;
				cw_data = rdb_q;
				rd_addr = LAST_ADDR;
			end
			lsde_pkg::ST_STEP_B: begin
				// end pixel is written before the sweep reads it as a neighbor
				cw_en   = 1'b1;
				cw_addr = LAST_ADDR;
				cw_data = rdb_q;
				rd_addr = FIRST_IN;
			end
			lsde_pkg::ST_SWEEP: begin
				cw_en   = v_s2;
				cw_addr = addr_s2;
				cw_data = new_px;
				if (issue) rd_addr = rp_q[AW-1:0];
			end
			lsde_pkg::ST_READ:   ;
			lsde_pkg::ST_RESULT: ;
			default: ;
		endcase
	end

	// update datapath, one pixel per cycle in all three channels
	always_comb begin
		logic signed [lsde_pkg::LAP_W-1:0]  lap;
		logic signed [lsde_pkg::GP_W-1:0]   gp;
		logic signed [lsde_pkg::ACC_W-1:0]  acc;
		logic [lsde_pkg::ACC_W-2-CHW:0]     q;
		lap = '0;
		gp  = '0;
		acc = '0;
		q   = '0;
		for (int ch = 0; ch < NC; ch++) begin
			// stage 1: terms that do not depend on the updated left neighbor
			lap = $signed({2'b00, rdc_q[ch]}) - $signed({1'b0, cur_q[ch], 1'b0});
			pd_d[ch] = lsde_pkg::PD_W'($signed({1'b0, diff_q})) * lsde_pkg::PD_W'(lap);
			pa_d[ch] = lsde_pkg::PA_W'(adv_q) * lsde_pkg::PA_W'($signed({1'b0, rdc_q[ch]}));
			// stage 2, packed elements are unsigned so the sign is restored
			k_d[ch] = lsde_pkg::ACC_W'($signed({1'b0, c_s1[ch], 8'h00}))
			        + lsde_pkg::ACC_W'($signed(pd_s1[ch]))
			        - lsde_pkg::ACC_W'($signed(pa_s1[ch]));
			// stage 3: left neighbor term, truncate, floor and saturate
			gp  = lsde_pkg::GP_W'(gain_q) * lsde_pkg::GP_W'($signed({1'b0, prev_q[ch]}));
			acc = k_s2[ch] + lsde_pkg::ACC_W'(gp);
			q   = acc[lsde_pkg::ACC_W-2:CHW];
			if (acc[lsde_pkg::ACC_W-1]) begin
				// negative sum truncates to zero or below, background wins
				new_px[ch] = bg_s2[ch];
			end else if (q[lsde_pkg::ACC_W-2-CHW:CHW] != '0) begin
				new_px[ch] = '1;
			end else if (q[CHW-1:0] < bg_s2[ch]) begin
				new_px[ch] = bg_s2[ch];
			end else begin
				new_px[ch] = q[CHW-1:0];
			end
			read_rgb[ch] = (rdc_q[ch] < limit_q) ? rdc_q[ch] : limit_q;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (cw_en) colour_mem[cw_addr] <= cw_data;
		if (bw_en) bg_mem[bw_addr] <= bw_data;
		rdc_q <= colour_mem[rd_addr];
		rdb_q <= bg_mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsde_pkg::ST_CLEAR;
			cnt_q       <= '0;
			rp_q        <= '0;
			rv_q        <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) cnt_q <= '0;
			else if (state_q == lsde_pkg::ST_CLEAR || state_q == lsde_pkg::ST_FILL)
				cnt_q <= cnt_q + AW'(1);
			if (state_q == lsde_pkg::ST_STEP_B) rp_q <= SWEEP_RD0;
			else if (issue) rp_q <= rp_q + CW'(1);
			rv_q <= (state_q == lsde_pkg::ST_STEP_B) || issue;
			// the first inner pixel only primes the window
			v_s1 <= rv_q && (ra_q != FIRST_IN);
			v_s2 <= v_s1;
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q  <= lsde_pkg::DIFFUSION_RST;
			adv_q   <= lsde_pkg::ADVECTION_RST;
			limit_q <= lsde_pkg::LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lsde_pkg::REG_DIFFUSION: diff_q  <= cfg_data[lsde_pkg::DIFF_W-1:0];
				lsde_pkg::REG_ADVECTION: adv_q   <= $signed(cfg_data[lsde_pkg::ADV_W-1:0]);
				lsde_pkg::REG_LIMIT:     limit_q <= cfg_data[CHW-1:0];
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ra_q <= rd_addr;
		if (accept) begin
			fill_q              <= in_rgb;
			fill_bg_q           <= (func == lsde_pkg::FUNC_FILL_BG);
			gain_q              <= $signed({2'b00, diff_q}) + $signed({adv_q[lsde_pkg::ADV_W-1], adv_q});
			res_q.rgb           <= '0;
			res_q.index_error   <= !pix_ok && (func == lsde_pkg::FUNC_WRITE_PIXEL
			                       || func == lsde_pkg::FUNC_WRITE_BG
			                       || func == lsde_pkg::FUNC_READ);
		end
		if (state_q == lsde_pkg::ST_READ) res_q.rgb <= read_rgb;
		if (out_load) out_q <= res_q;

		if (state_q == lsde_pkg::ST_STEP_A) prev_q <= rdb_q;
		else if (v_s2) prev_q <= new_px;

		if (rv_q) begin
			cur_q   <= rdc_q;
			bgc_q   <= rdb_q;
			pd_s1   <= pd_d;
			pa_s1   <= pa_d;
			c_s1    <= cur_q;
			bg_s1   <= bgc_q;
			addr_s1 <= ra_q - AW'(1);
		end
		k_s2    <= k_d;
		bg_s2   <= bg_s1;
		addr_s2 <= addr_s1;
	end

	// checks
	a_sweep_addr: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (addr_s2 != '0) && (addr_s2 <= INNER_LAST))
		else $error("sweep write outside the inner pixels");

	a_pipe_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lsde_pkg::ST_SWEEP) |-> !rv_q && !v_s1 && !v_s2)
		else $error("step pipeline busy outside the sweep");

	a_rp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= RD_END)
		else $error("sweep read pointer past the strip");

	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lsde_pkg::ST_RESULT) && !out_valid_q |=> out_valid_q)
		else $error("pending result not moved to the output register");

endmodule

// ===== tb/led_strip_diffusion_engine_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_diffusion_engine_top_test
// Self-checking bench for the LED strip diffusion engine. A queue-fed driver
// offers pixel operations with random gaps, and a shadow copy of both pixel
// stores predicts each reply at the moment an item is accepted. A monitor
// stalls at random and compares every reply field by field. Gain and
// brightness registers are rewritten between phases while the engine is idle.
// ----------------------------------------------------------------------------
module led_strip_diffusion_engine_top_test;

	localparam int PIXELS       = lsde_pkg::PIXEL_COUNT_DEF;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD    = 700;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 110;

	localparam logic [lsde_pkg::FUNC_W-1:0]    FUNC_SPARE_6 = 3'd6;
	localparam logic [lsde_pkg::FUNC_W-1:0]    FUNC_SPARE_7 = 3'd7;
	localparam logic [lsde_pkg::CFG_IDX_W-1:0] REG_SPARE    = 2'd3;

	typedef struct {
		logic [lsde_pkg::FUNC_W-1:0]  code;
		logic [lsde_pkg::INDEX_W-1:0] idx;
		logic [lsde_pkg::CH_W-1:0]    r;
		logic [lsde_pkg::CH_W-1:0]    g;
		logic [lsde_pkg::CH_W-1:0]    b;
	} strip_op_t;

	typedef struct {
		logic [lsde_pkg::CH_W-1:0]    r;
		logic [lsde_pkg::CH_W-1:0]    g;
		logic [lsde_pkg::CH_W-1:0]    b;
		logic                         err;
		logic [lsde_pkg::FUNC_W-1:0]  code;
		logic [lsde_pkg::INDEX_W-1:0] idx;
	} strip_reply_t;

	typedef struct {
		logic [lsde_pkg::CFG_IDX_W-1:0]  index;
		logic [lsde_pkg::CFG_DATA_W-1:0] data;
	} reg_write_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	logic [lsde_pkg::FUNC_W-1:0]     func = '0;
	logic [lsde_pkg::INDEX_W-1:0]    pixel_index = '0;
	logic [lsde_pkg::CH_W-1:0]       red_in = '0;
	logic [lsde_pkg::CH_W-1:0]       green_in = '0;
	logic [lsde_pkg::CH_W-1:0]       blue_in = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	logic [lsde_pkg::CH_W-1:0]       red_out;
	logic [lsde_pkg::CH_W-1:0]       green_out;
	logic [lsde_pkg::CH_W-1:0]       blue_out;
	logic                            index_error;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [lsde_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lsde_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the engine state
	logic [lsde_pkg::CH_W-1:0] strip_fg [PIXELS][lsde_pkg::NUM_CH];
	logic [lsde_pkg::CH_W-1:0] strip_bg [PIXELS][lsde_pkg::NUM_CH];
	int                        k_diff;
	int                        k_adv;
	logic [lsde_pkg::CH_W-1:0] bright_cap;

	strip_op_t    op_queue[$];
	strip_reply_t reply_queue[$];
	reg_write_t   reg_queue[$];

	strip_op_t  tx_item;
	reg_write_t reg_item;
	int         tx_gap = 0;
	int         rx_hold = 0;
	int         rx_hold_req = 0;
	bit         tx_mode = 1'b1;
	bit         rx_mode = 1'b1;
	int         mismatch_count = 0;
	int         idle_cycles = 0;

	led_strip_diffusion_engine_top uut (.*);

	always #5 clk = ~clk;

	function automatic strip_reply_t apply_strip_op(strip_op_t op);
		strip_reply_t              rep;
		logic [lsde_pkg::CH_W-1:0] paint [lsde_pkg::NUM_CH];
		logic [lsde_pkg::CH_W-1:0] shade [lsde_pkg::NUM_CH];
		logic                      in_range;
		int                        i;
		int                        ch;
		int                        acc;
		int                        q;
		paint[0] = op.r;
		paint[1] = op.g;
		paint[2] = op.b;
		rep.r = '0;
		rep.g = '0;
		rep.b = '0;
		rep.err = 1'b0;
		rep.code = op.code;
		rep.idx = op.idx;
		in_range = op.idx < PIXELS;
		case (op.code) inside
			lsde_pkg::FUNC_WRITE_PIXEL, lsde_pkg::FUNC_WRITE_BG: begin
				if (!in_range) begin
					rep.err = 1'b1;
				end else begin
					for (ch = 0; ch < lsde_pkg::NUM_CH; ch++) begin
						if (op.code == lsde_pkg::FUNC_WRITE_PIXEL)
							strip_fg[op.idx][ch] = paint[ch];
						else strip_bg[op.idx][ch] = paint[ch];
					end
				end
			end
			lsde_pkg::FUNC_FILL_PIXEL, lsde_pkg::FUNC_FILL_BG: begin
				for (i = 0; i < PIXELS; i++) begin
					for (ch = 0; ch < lsde_pkg::NUM_CH; ch++) begin
						if (op.code == lsde_pkg::FUNC_FILL_PIXEL) strip_fg[i][ch] = paint[ch];
						else strip_bg[i][ch] = paint[ch];
					end
				end
			end
			lsde_pkg::FUNC_STEP: begin
				for (ch = 0; ch < lsde_pkg::NUM_CH; ch++) begin
					strip_fg[0][ch] = strip_bg[0][ch];
					strip_fg[PIXELS-1][ch] = strip_bg[PIXELS-1][ch];
				end
				// in-place sweep, pixel i sees the updated i-1
				for (i = 1; i < PIXELS - 1; i++) begin
					for (ch = 0; ch < lsde_pkg::NUM_CH; ch++) begin
						acc = 256 * int'(strip_fg[i][ch])
							+ k_diff * (int'(strip_fg[i+1][ch]) - 2 * int'(strip_fg[i][ch])
								+ int'(strip_fg[i-1][ch]))
							- k_adv * (int'(strip_fg[i+1][ch]) - int'(strip_fg[i-1][ch]));
						// truncate toward zero
						q = (acc >= 0) ? (acc >>> 8) : -((-acc) >>> 8);
						if (q < int'(strip_bg[i][ch])) q = int'(strip_bg[i][ch]);
						if (q > 255) q = 255;
						strip_fg[i][ch] = q[lsde_pkg::CH_W-1:0];
					end
				end
			end
			lsde_pkg::FUNC_READ: begin
				if (!in_range) begin
					rep.err = 1'b1;
				end else begin
					for (ch = 0; ch < lsde_pkg::NUM_CH; ch++)
						shade[ch] = (strip_fg[op.idx][ch] < bright_cap) ?
							strip_fg[op.idx][ch] : bright_cap;
					rep.r = shade[0];
					rep.g = shade[1];
					rep.b = shade[2];
				end
			end
			default: ;
		endcase
		return rep;
	endfunction

	function automatic logic [lsde_pkg::CH_W-1:0] pick_level();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return '0;
		if (r < 20) return '1;
		return lsde_pkg::CH_W'($urandom_range(0, 255));
	endfunction

	function automatic strip_op_t random_op();
		strip_op_t op;
		int        pick;
		int        where;
		pick = $urandom_range(0, 99);
		if (pick < 30) op.code = lsde_pkg::FUNC_WRITE_PIXEL;
		else if (pick < 42) op.code = lsde_pkg::FUNC_WRITE_BG;
		else if (pick < 75) op.code = lsde_pkg::FUNC_READ;
		else if (pick < 87) op.code = lsde_pkg::FUNC_STEP;
		else if (pick < 91) op.code = lsde_pkg::FUNC_FILL_PIXEL;
		else if (pick < 95) op.code = lsde_pkg::FUNC_FILL_BG;
		else if (pick < 97) op.code = FUNC_SPARE_6;
		else op.code = FUNC_SPARE_7;
		where = $urandom_range(0, 99);
		if (where < 75) begin
			op.idx = lsde_pkg::INDEX_W'($urandom_range(0, PIXELS - 1));
		end else if (where < 90) begin
			case ($urandom_range(0, 3))
				0: op.idx = '0;
				1: op.idx = lsde_pkg::INDEX_W'(1);
				2: op.idx = lsde_pkg::INDEX_W'(PIXELS - 2);
				default: op.idx = lsde_pkg::INDEX_W'(PIXELS - 1);
			endcase
		end else begin
			op.idx = lsde_pkg::INDEX_W'($urandom_range(PIXELS, 511));
		end
		op.r = pick_level();
		op.g = pick_level();
		op.b = pick_level();
		return op;
	endfunction

	task automatic queue_op(input logic [lsde_pkg::FUNC_W-1:0] code, input int idx,
			input int r, input int g, input int b);
		strip_op_t op;
		op.code = code;
		op.idx = lsde_pkg::INDEX_W'(idx);
		op.r = lsde_pkg::CH_W'(r);
		op.g = lsde_pkg::CH_W'(g);
		op.b = lsde_pkg::CH_W'(b);
		op_queue.push_back(op);
	endtask

	task automatic queue_reg(input logic [lsde_pkg::CFG_IDX_W-1:0] index, input int data);
		reg_write_t w;
		w.index = index;
		w.data = lsde_pkg::CFG_DATA_W'(data);
		reg_queue.push_back(w);
	endtask

	// sender pause: everything offered, accepted and answered
	task automatic wait_idle();
		do @(negedge clk);
		while (op_queue.size() != 0 || in_valid || reply_queue.size() != 0 ||
			reg_queue.size() != 0 || cfg_valid);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	// item driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				reply_queue.push_back(apply_strip_op(tx_item));
				if (tx_mode) begin
					case ($urandom_range(0, 9)) inside
						[0:4]: tx_gap = 0;
						[5:8]: tx_gap = $urandom_range(1, 3);
						default: tx_gap = $urandom_range(8, 40);
					endcase
				end
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (op_queue.size() != 0) begin
					tx_item = op_queue.pop_front();
					in_valid <= 1'b1;
					func <= tx_item.code;
					pixel_index <= tx_item.idx;
					red_in <= tx_item.r;
					green_in <= tx_item.g;
					blue_in <= tx_item.b;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// register writer
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_item.index)
					lsde_pkg::REG_DIFFUSION: k_diff = int'(reg_item.data[lsde_pkg::DIFF_W-1:0]);
					lsde_pkg::REG_ADVECTION: k_adv = int'($signed(reg_item.data));
					lsde_pkg::REG_LIMIT: bright_cap = reg_item.data[lsde_pkg::CH_W-1:0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_queue.size() != 0) begin
					reg_item = reg_queue.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= reg_item.index;
					cfg_data <= reg_item.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// reply monitor and receiver stall
	always @(posedge clk) begin
		strip_reply_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (reply_queue.size() == 0) begin
					report_mismatch("reply with no item outstanding");
				end else begin
					want = reply_queue.pop_front();
					if (red_out !== want.r)
						report_mismatch($sformatf("red_out %0d, want %0d (func %0d pixel %0d)",
							red_out, want.r, want.code, want.idx));
					if (green_out !== want.g)
						report_mismatch($sformatf("green_out %0d, want %0d (func %0d pixel %0d)",
							green_out, want.g, want.code, want.idx));
					if (blue_out !== want.b)
						report_mismatch($sformatf("blue_out %0d, want %0d (func %0d pixel %0d)",
							blue_out, want.b, want.code, want.idx));
					if (index_error !== want.err)
						report_mismatch($sformatf("index_error %b, want %b (func %0d pixel %0d)",
							index_error, want.err, want.code, want.idx));
				end
			end
			if (rx_hold_req > 0) begin
				rx_hold = rx_hold_req;
				rx_hold_req = 0;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_mode && $urandom_range(0, 99) < 25) begin
				rx_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		int phase;
		for (int i = 0; i < PIXELS; i++) begin
			for (int ch = 0; ch < lsde_pkg::NUM_CH; ch++) begin
				strip_fg[i][ch] = '0;
				strip_bg[i][ch] = '0;
			end
		end
		k_diff = int'(lsde_pkg::DIFFUSION_RST);
		k_adv = int'(lsde_pkg::ADVECTION_RST);
		bright_cap = lsde_pkg::LIMIT_RST;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed items at reset register values
		queue_op(lsde_pkg::FUNC_READ, 0, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_WRITE_PIXEL, 0, 255, 128, 7);
		queue_op(lsde_pkg::FUNC_READ, 0, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_WRITE_PIXEL, PIXELS - 1, 1, 2, 3);
		queue_op(lsde_pkg::FUNC_READ, PIXELS - 1, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_WRITE_PIXEL, PIXELS, 9, 9, 9);
		queue_op(lsde_pkg::FUNC_WRITE_BG, 511, 255, 255, 255);
		queue_op(lsde_pkg::FUNC_READ, PIXELS, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 511, 255, 255, 255);
		queue_op(FUNC_SPARE_6, 5, 255, 255, 255);
		queue_op(FUNC_SPARE_7, 511, 255, 255, 255);
		queue_op(lsde_pkg::FUNC_WRITE_BG, 5, 10, 20, 30);
		queue_op(lsde_pkg::FUNC_FILL_PIXEL, 0, 200, 0, 255);
		queue_op(lsde_pkg::FUNC_READ, 5, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_STEP, 0, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 0, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 5, 0, 0, 0);
		// dark pixel among bright ones overshoots, bright among dark undershoots
		queue_op(lsde_pkg::FUNC_WRITE_PIXEL, 150, 0, 255, 0);
		queue_op(lsde_pkg::FUNC_STEP, 0, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 149, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 150, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 151, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_FILL_BG, 0, 1, 2, 3);
		queue_op(lsde_pkg::FUNC_STEP, 0, 0, 0, 0);
		queue_op(lsde_pkg::FUNC_READ, 1, 0, 0, 0);

		for (phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					queue_reg(lsde_pkg::REG_DIFFUSION, 0);
					queue_reg(lsde_pkg::REG_ADVECTION, 9'h100);
					queue_reg(lsde_pkg::REG_LIMIT, 0);
					queue_reg(REG_SPARE, 9'h1ff);
				end
				1: begin
					queue_reg(lsde_pkg::REG_DIFFUSION, 255);
					queue_reg(lsde_pkg::REG_ADVECTION, 255);
					queue_reg(lsde_pkg::REG_LIMIT, 255);
				end
				2: begin
					queue_reg(lsde_pkg::REG_DIFFUSION, 9'h180);
					queue_reg(lsde_pkg::REG_ADVECTION, 9'h101);
					queue_reg(lsde_pkg::REG_LIMIT, 9'h1ff);
				end
				default: begin
					queue_reg(lsde_pkg::REG_LIMIT, $urandom_range(0, 511));
					queue_reg(lsde_pkg::REG_ADVECTION, $urandom_range(0, 511));
					queue_reg(lsde_pkg::REG_DIFFUSION, $urandom_range(0, 511));
					if ($urandom_range(0, 1)) queue_reg(REG_SPARE, $urandom_range(0, 511));
				end
			endcase
			wait_idle();
			tx_mode = (phase % 4 != 2);
			rx_mode = (phase % 3 != 0);
			if (phase == 3) begin
				// receiver blocks while items keep coming, so the engine backs up
				tx_mode = 1'b0;
				rx_hold_req = LONG_HOLD;
			end
			repeat (PHASE_ITEMS) op_queue.push_back(random_op());
		end

		wait_idle();
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/lsde_pkg.sv
src/led_strip_diffusion_engine_top.sv
tb/led_strip_diffusion_engine_top_test.sv
